FILE: sv/sadc_pkg.sv
package sadc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int DENS_W     = 7;
    localparam int LEN_W      = 11;
    localparam int LEN_REGS   = 4;
    localparam int STAGE_W    = 2;
    localparam int CNT_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int RND_W      = PROD_W - (GAIN_W - 1);
    localparam int SUM_W      = RND_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN    = 3'd0,
        REG_DENSITY = 3'd1,
        REG_LEN0    = 3'd2,
        REG_LEN1    = 3'd3,
        REG_LEN2    = 3'd4,
        REG_LEN3    = 3'd5
    } t_reg_idx;

    localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd16384;
    localparam logic [DENS_W-1:0]        DENS_RST = 7'd0;
    localparam logic [LEN_REGS-1:0][LEN_W-1:0] LEN_RST =
        {11'd277, 11'd379, 11'd107, 11'd142};

    // density thresholds for one, two, three and four active stages
    localparam logic [DENS_W-1:0] DENS_T1 = 7'd20;
    localparam logic [DENS_W-1:0] DENS_T2 = 7'd40;
    localparam logic [DENS_W-1:0] DENS_T3 = 7'd55;
    localparam logic [DENS_W-1:0] DENS_T4 = 7'd75;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (GAIN_W - 2);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic signed [GAIN_W-1:0]        gain;
        logic [DENS_W-1:0]               density;
        logic [LEN_REGS-1:0][LEN_W-1:0]  len;
    } t_cfg;

    typedef struct packed {
        logic               load_in;
        logic               rd_en;
        logic [STAGE_W-1:0] rd_stage;
        logic               mul_d;
        logic               upd_v;
        logic               mul_v;
        logic               upd_y;
        logic               load_out;
    } t_dp_cmd;

    // Q1.15 x Q1.23 product down to Q2.23, round half up
    function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + RND_HALF;
        return t[PROD_W-1:GAIN_W-1];
    endfunction

    function automatic t_sample sat_sample(input logic signed [SUM_W-1:0] s);
        if (s[SUM_W-1:SAMPLE_W-1] == '0 || s[SUM_W-1:SAMPLE_W-1] == '1) begin
            return s[SAMPLE_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: sv/sadc_cfg.sv
module sadc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sadc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sadc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sadc_pkg::t_cfg                   o_cfg
);

    sadc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain    <= sadc_pkg::GAIN_RST;
            r_cfg.density <= sadc_pkg::DENS_RST;
            r_cfg.len     <= sadc_pkg::LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sadc_pkg::REG_GAIN:    r_cfg.gain    <= i_cfg_data[sadc_pkg::GAIN_W-1:0];
                sadc_pkg::REG_DENSITY: r_cfg.density <= i_cfg_data[sadc_pkg::DENS_W-1:0];
                sadc_pkg::REG_LEN0:    r_cfg.len[0]  <= i_cfg_data[sadc_pkg::LEN_W-1:0];
                sadc_pkg::REG_LEN1:    r_cfg.len[1]  <= i_cfg_data[sadc_pkg::LEN_W-1:0];
                sadc_pkg::REG_LEN2:    r_cfg.len[2]  <= i_cfg_data[sadc_pkg::LEN_W-1:0];
                sadc_pkg::REG_LEN3:    r_cfg.len[3]  <= i_cfg_data[sadc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/sadc_ctrl.sv
module sadc_ctrl #(
    parameter int NUM_STAGES = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sadc_pkg::DENS_W-1:0]   i_density,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sadc_pkg::t_dp_cmd             o_cmd
);

    localparam int USED = (NUM_STAGES < sadc_pkg::LEN_REGS) ? NUM_STAGES : sadc_pkg::LEN_REGS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MULD,
        S_UPDV,
        S_MULV,
        S_UPDY,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [sadc_pkg::STAGE_W-1:0]    r_stage;
    logic [sadc_pkg::STAGE_W-1:0]    r_last;
    logic                            r_out_valid;
    logic [sadc_pkg::CNT_W-1:0]      w_cnt;
    logic [sadc_pkg::CNT_W-1:0]      w_raw;

    always_comb begin
        if (i_density < sadc_pkg::DENS_T1)      w_raw = 3'd0;
        else if (i_density < sadc_pkg::DENS_T2) w_raw = 3'd1;
        else if (i_density < sadc_pkg::DENS_T3) w_raw = 3'd2;
        else if (i_density < sadc_pkg::DENS_T4) w_raw = 3'd3;
        else                                    w_raw = 3'd4;
        w_cnt = (w_raw > sadc_pkg::CNT_W'(USED)) ? sadc_pkg::CNT_W'(USED) : w_raw;
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load_in = i_in_valid;
            S_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_stage = r_stage;
            end
            S_MULD: o_cmd.mul_d = 1'b1;
            S_UPDV: o_cmd.upd_v = 1'b1;
            S_MULV: o_cmd.mul_v = 1'b1;
            S_UPDY: begin
                o_cmd.upd_y = 1'b1;
                // next stage's read overlaps this stage's final add
                if (r_stage != r_last) begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_stage = r_stage + 1'b1;
                end
            end
            S_DONE: o_cmd.load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_stage <= '0;
                        r_last  <= sadc_pkg::STAGE_W'(w_cnt - 3'd1);
                        r_state <= (w_cnt == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ: r_state <= S_MULD;
                S_MULD: r_state <= S_UPDV;
                S_UPDV: r_state <= S_MULV;
                S_MULV: r_state <= S_UPDY;
                S_UPDY: begin
                    if (r_stage == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_stage <= r_stage + 1'b1;
                        r_state <= S_MULD;
                    end
                end
                S_DONE: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/sadc_dp.sv
module sadc_dp #(
    parameter int MAX_DELAY  = 1024,
    parameter int NUM_STAGES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sadc_pkg::t_cfg                     i_cfg,
    input  sadc_pkg::t_dp_cmd                  i_cmd,
    input  logic [2*sadc_pkg::SAMPLE_W-1:0]    i_in_data,
    output logic [2*sadc_pkg::SAMPLE_W-1:0]    o_out_data
);

    localparam int SW    = sadc_pkg::SAMPLE_W;
    localparam int USED  = (NUM_STAGES < sadc_pkg::LEN_REGS) ? NUM_STAGES : sadc_pkg::LEN_REGS;
    localparam int STG_W = (USED > 1) ? $clog2(USED) : 1;
    localparam int PW    = $clog2(MAX_DELAY);
    localparam int LW    = $clog2(MAX_DELAY + 1);
    localparam int AW    = ((LW > sadc_pkg::LEN_W) ? LW : sadc_pkg::LEN_W) + 1;
    localparam int DEPTH = 2 ** (STG_W + PW);

    // write position per stage, shared by both channels; wrap flag marks a full line
    logic [PW-1:0]     r_wp   [USED];
    logic              r_wrap [USED];
    logic [STG_W-1:0]  r_cur_stage;
    logic [PW-1:0]     r_cur_wp;
    logic              r_hit;

    logic [STG_W-1:0]  w_rs;
    logic [AW-1:0]     w_len;
    logic [AW-1:0]     w_wpx;
    logic [AW-1:0]     w_rdx;
    logic [PW-1:0]     w_rd_pos;
    logic              w_hit;

    always_comb begin
        w_rs  = i_cmd.rd_stage[STG_W-1:0];
        w_len = AW'(i_cfg.len[i_cmd.rd_stage]);
        if (w_len == '0) begin
            w_len = AW'(1);
        end else if (w_len > AW'(MAX_DELAY)) begin
            w_len = AW'(MAX_DELAY);
        end
        w_wpx = AW'(r_wp[w_rs]);
        if (w_wpx >= w_len) begin
            w_rdx = w_wpx - w_len;
        end else begin
            w_rdx = w_wpx + AW'(MAX_DELAY) - w_len;
        end
        w_rd_pos = w_rdx[PW-1:0];
        // before the first wrap only positions below the write pointer hold data
        w_hit    = r_wrap[w_rs] || (w_rd_pos < r_wp[w_rs]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < USED; i++) begin
                r_wp[i]   <= '0;
                r_wrap[i] <= 1'b0;
            end
        end else if (i_cmd.upd_y) begin
            if (r_cur_wp == PW'(MAX_DELAY - 1)) begin
                r_wp[r_cur_stage]   <= '0;
                r_wrap[r_cur_stage] <= 1'b1;
            end else begin
                r_wp[r_cur_stage]   <= r_cur_wp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cur_stage <= w_rs;
            r_cur_wp    <= r_wp[w_rs];
            r_hit       <= w_hit;
        end
    end

    for (genvar ch = 0; ch < 2; ch++) begin : g_lane
        sadc_pkg::t_sample                      r_mem [DEPTH];
        sadc_pkg::t_sample                      r_rdata;
        sadc_pkg::t_sample                      r_x;
        sadc_pkg::t_sample                      r_d;
        sadc_pkg::t_sample                      r_out;
        logic signed [sadc_pkg::PROD_W-1:0]     r_prod;
        sadc_pkg::t_sample                      w_d;
        sadc_pkg::t_sample                      w_v;
        sadc_pkg::t_sample                      w_y;

        always_comb begin
            w_d = r_hit ? r_rdata : '0;
            w_v = sadc_pkg::sat_sample(sadc_pkg::SUM_W'(r_x)
                                       - sadc_pkg::SUM_W'(sadc_pkg::rnd_shift(r_prod)));
            w_y = sadc_pkg::sat_sample(sadc_pkg::SUM_W'(r_d)
                                       + sadc_pkg::SUM_W'(sadc_pkg::rnd_shift(r_prod)));
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.rd_en) begin
                r_rdata <= r_mem[{w_rs, w_rd_pos}];
            end
            if (i_cmd.upd_v) begin
                r_mem[{r_cur_stage, r_cur_wp}] <= w_v;
            end
        end

        // r_x holds the stage input, then v, then the stage output
        always_ff @(posedge i_clk) begin
            if (i_cmd.load_in) begin
                r_x <= i_in_data[ch*SW +: SW];
            end else if (i_cmd.upd_v) begin
                r_x <= w_v;
            end else if (i_cmd.upd_y) begin
                r_x <= w_y;
            end
            if (i_cmd.mul_d) begin
                r_d    <= w_d;
                r_prod <= sadc_pkg::PROD_W'(i_cfg.gain) * sadc_pkg::PROD_W'(w_d);
            end else if (i_cmd.mul_v) begin
                r_prod <= sadc_pkg::PROD_W'(i_cfg.gain) * sadc_pkg::PROD_W'(r_x);
            end
            if (i_cmd.load_out) begin
                r_out <= r_x;
            end
        end

        assign o_out_data[ch*SW +: SW] = r_out;
    end

endmodule

FILE: sv/stereo_allpass_diffuser_chain.sv
// Sequence: with no stage active the input pair is loaded straight to the output; with n
//   active stages each stage does multiply, subtract, multiply, add after its delay read.
// Flow: a new stereo pair is taken only after the last result is loaded for output, which
//   waits on a stall; each stage uses the single multiplier per channel twice in turn.
// Reset: control state, configuration and write positions return to their defaults; the
//   delay memory is not swept, entries never written since reset read as zero.
module stereo_allpass_diffuser_chain #(
    parameter int MAX_DELAY  = 1024,
    parameter int NUM_STAGES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [2*sadc_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // left_in, right_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [2*sadc_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // left_out, right_out
    input  logic                               i_cfg_we,
    input  logic [sadc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sadc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    sadc_pkg::t_cfg    w_cfg;
    sadc_pkg::t_dp_cmd w_cmd;

    sadc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sadc_ctrl #(
        .NUM_STAGES (NUM_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_density   (w_cfg.density),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    sadc_dp #(
        .MAX_DELAY  (MAX_DELAY),
        .NUM_STAGES (NUM_STAGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a request is in flight");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_in, w_cmd.mul_d, w_cmd.upd_v, w_cmd.mul_v,
                  w_cmd.upd_y, w_cmd.load_out}))
        else $error("datapath commands overlap");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten before it was taken");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.load_out))
        else $error("output valid without a result load");

endmodule
